FILE: src/kbms_pkg.sv
// ----------------------------------------------------------------------------
// kbms_pkg: shared types and constants for the k-mer bottom-k sketch block
// Command format between the front and back ends, hash constants, state
// machine encodings and the residue letter tables.
// ----------------------------------------------------------------------------
`default_nettype none

package kbms_pkg;

  localparam int KMAX          = 32;
  localparam int KLEN_W        = 6;
  localparam int IDX_W         = 10;
  localparam int IN_W          = 24;
  localparam int OUT_W         = 136;
  localparam int SKETCH_DEFAULT = 1000;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd21;

  localparam logic [63:0] MM_C1    = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2    = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_C3    = 64'h0000000052dce729;
  localparam logic [63:0] MM_C4    = 64'h0000000038495ab5;
  localparam logic [63:0] MM_F1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2    = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_SEED  = 64'd42;
  localparam logic [63:0] ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

  localparam logic [7:0] RESIDUE_MAX = 8'd20;

  localparam logic REG_KLEN = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_SKIP,
    CMD_HASH,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   index;
    logic [KLEN_W-1:0]  len;
    logic [8*KMAX-1:0]  str;
  } cmd_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LL,
    M_LH,
    M_HL,
    M_CROSS,
    M_SUM
  } mul_step_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_KEY,
    H_KM1,
    H_KM2,
    H_KMIX,
    H_RND1,
    H_RND2,
    H_RND3,
    H_FIN1,
    H_FIN2,
    H_FIN3,
    H_FX,
    H_FM1,
    H_FM2,
    H_SUM
  } hash_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HASH,
    B_TOPCMP,
    B_SHRD,
    B_SHCMP,
    B_PLACE,
    B_RDWAIT,
    B_DONE
  } back_state_t;

  function automatic logic [7:0] dna_letter(input logic [1:0] c);
    logic [7:0] l;
    case (c)
      2'd0:    l = 8'h41;
      2'd1:    l = 8'h43;
      2'd2:    l = 8'h47;
      default: l = 8'h54;
    endcase
    return l;
  endfunction

  // Residue codes beyond the table read as the unknown residue.
  function automatic logic [7:0] protein_letter(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'd0:    l = 8'h41;
      8'd1:    l = 8'h43;
      8'd2:    l = 8'h47;
      8'd3:    l = 8'h54;
      8'd4:    l = 8'h44;
      8'd5:    l = 8'h45;
      8'd6:    l = 8'h46;
      8'd7:    l = 8'h48;
      8'd8:    l = 8'h49;
      8'd9:    l = 8'h4B;
      8'd10:   l = 8'h4C;
      8'd11:   l = 8'h4D;
      8'd12:   l = 8'h4E;
      8'd13:   l = 8'h50;
      8'd14:   l = 8'h51;
      8'd15:   l = 8'h52;
      8'd16:   l = 8'h53;
      8'd17:   l = 8'h56;
      8'd18:   l = 8'h57;
      8'd19:   l = 8'h59;
      default: l = 8'h58;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: src/kmer_bottom_k_minhash_sketch.sv
// ----------------------------------------------------------------------------
// kmer_bottom_k_minhash_sketch: bottom-k MinHash sketch of a symbol stream
// Symbols arrive one request at a time on the slave stream; every request
// gives exactly one result on the master stream.
//
// s_tdata carries the opcode, the symbol and the entry index. A push moves
// the symbol into the window and, once k symbols of the sequence are in,
// hashes the k-mer and tries to insert it into the sorted sketch. A start
// request empties the window and the sketch; a read request returns one
// sorted entry. The APB port sets k and the DNA or protein mode between
// sequences.
//
// A push that completes a k-mer runs through the multi-cycle hash unit,
// then every stored entry larger than the new hash moves up one place, one
// at a time, to make room. One request is worked on at a time; a two-entry
// queue lets the front accept while the back is busy. After reset the sketch
// is empty at once (no clearing pass), k is 21 and the mode is DNA. When the
// receiver stalls the result waits in the output register and the queue and
// the front's staging register fill, after which s_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_bottom_k_minhash_sketch #(
  parameter int SKETCH_SIZE = kbms_pkg::SKETCH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // opcode[1:0], symbol_code[9:2], entry_index[19:10], zero fill
  input  logic [kbms_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // hash_valid[0], kmer_hash[64:1], hash_kept[65], entry_value[129:66]
  output logic [kbms_pkg::OUT_W-1:0] m_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import kbms_pkg::*;

  logic [KLEN_W-1:0] klen;
  logic              protein;
  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, protein} : {26'd0, klen};

  always_ff @(posedge clk) begin
    if (rst) begin
      klen    <= KLEN_RESET;
      protein <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_KLEN) klen <= pwdata[KLEN_W-1:0];
      else protein <= pwdata[0];
    end
  end

  kbms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .klen     (klen),
    .protein  (protein),
    .q_push   (q_push),
    .q_entry  (q_in),
    .q_full   (q_full)
  );

  kbms_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  kbms_back #(
    .SKETCH_SIZE (SKETCH_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_entry  (q_out),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

FILE: src/kbms_mul64.sv
// ----------------------------------------------------------------------------
// kbms_mul64: multi-cycle 64x64 multiplier, low 64 bits of the product
// One shared 32x32 multiplier forms three partial products in turn; the
// product is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module kbms_mul64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import kbms_pkg::*;

  mul_step_t   step, step_next;
  logic [63:0] ra, rb, p0;
  logic [31:0] p1, p2, mid;
  logic [31:0] mx, my;
  logic [63:0] pp;

  always_comb begin
    step_next = step;
    mx = ra[31:0];
    my = rb[31:0];
    case (step)
      M_IDLE:  if (start) step_next = M_LL;
      M_LL:    step_next = M_LH;
      M_LH:    begin
        my = rb[63:32];
        step_next = M_HL;
      end
      M_HL:    begin
        mx = ra[63:32];
        step_next = M_CROSS;
      end
      M_CROSS: step_next = M_SUM;
      M_SUM:   step_next = M_IDLE;
      default: step_next = M_IDLE;
    endcase
  end

  assign pp = mx * my;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= M_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (step == M_SUM);
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      M_IDLE:  if (start) begin
        ra <= a;
        rb <= b;
      end
      M_LL:    p0 <= pp;
      M_LH:    p1 <= pp[31:0];
      M_HL:    p2 <= pp[31:0];
      M_CROSS: mid <= p1 + p2;
      M_SUM:   prod <= p0 + {mid, 32'd0};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/kbms_murmur.sv
// ----------------------------------------------------------------------------
// kbms_murmur: sequential MurmurHash3 x64_128 engine, low 64 bits
// Walks the key one 64-bit word at a time through a shared multiplier,
// then applies the length fold and both finalisation mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module kbms_murmur (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [8*kbms_pkg::KMAX-1:0]           key,
  input  logic [kbms_pkg::KLEN_W-1:0]           key_len,
  output logic                                  done,
  output logic [63:0]                           hash
);
  import kbms_pkg::*;

  hash_state_t       state, state_next;
  logic [8*KMAX-1:0] str;
  logic [KLEN_W-1:0] len;
  logic [1:0]        w;
  logic [63:0]       h1, h2, x;
  logic              sel;

  logic        mstart, mdone;
  logic [63:0] ma, mb, mprod;
  logic [63:0] word, mixed, fsrc;
  logic        lane, full, more;
  logic [2:0]  wn;

  kbms_mul64 u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (mprod)
  );

  // Bytes past the key length read as zero, as in the tail load.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word[8*b +: 8] = ({1'b0, w, 3'(b)} < len) ? str[64*w + 8*b +: 8] : 8'd0;
    end
  end

  assign lane  = w[0];
  assign full  = {1'b0, w[1]} < len[5:4];
  assign wn    = {1'b0, w} + 3'd1;
  assign more  = (w != 2'd3) && ({wn, 3'b000} < len);
  assign mixed = mprod ^ {33'd0, mprod[63:33]};
  assign fsrc  = sel ? h2 : h1;

  always_comb begin
    state_next = state;
    mstart = 1'b0;
    ma = word;
    mb = lane ? MM_C2 : MM_C1;
    case (state)
      H_IDLE: if (start) state_next = H_KEY;
      H_KEY:  begin
        mstart = 1'b1;
        state_next = H_KM1;
      end
      H_KM1:  if (mdone) begin
        mstart = 1'b1;
        ma = lane ? {mprod[30:0], mprod[63:31]} : {mprod[32:0], mprod[63:33]};
        mb = lane ? MM_C1 : MM_C2;
        state_next = H_KM2;
      end
      H_KM2:  if (mdone) state_next = H_KMIX;
      H_KMIX: begin
        if (full) state_next = H_RND1;
        else if (more) state_next = H_KEY;
        else state_next = H_FIN1;
      end
      H_RND1: state_next = H_RND2;
      H_RND2: state_next = H_RND3;
      H_RND3: state_next = more ? H_KEY : H_FIN1;
      H_FIN1: state_next = H_FIN2;
      H_FIN2: state_next = H_FIN3;
      H_FIN3: state_next = H_FX;
      H_FX:   begin
        mstart = 1'b1;
        ma = fsrc ^ {33'd0, fsrc[63:33]};
        mb = MM_F1;
        state_next = H_FM1;
      end
      H_FM1:  if (mdone) begin
        mstart = 1'b1;
        ma = mixed;
        mb = MM_F2;
        state_next = H_FM2;
      end
      H_FM2:  if (mdone) state_next = sel ? H_SUM : H_FX;
      H_SUM:  state_next = H_IDLE;
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == H_SUM);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: if (start) begin
        str <= key;
        len <= key_len;
        w   <= 2'd0;
        h1  <= MM_SEED;
        h2  <= MM_SEED;
        sel <= 1'b0;
      end
      H_KM2:  if (mdone) x <= mprod;
      H_KMIX: begin
        if (lane) h2 <= h2 ^ x;
        else h1 <= h1 ^ x;
        if (!full && more) w <= w + 2'd1;
      end
      H_RND1: begin
        if (lane) h2 <= {h2[32:0], h2[63:33]} + h1;
        else h1 <= {h1[36:0], h1[63:37]} + h2;
      end
      H_RND2: begin
        if (lane) h2 <= {h2[61:0], 2'b00} + h2;
        else h1 <= {h1[61:0], 2'b00} + h1;
      end
      H_RND3: begin
        if (lane) h2 <= h2 + MM_C4;
        else h1 <= h1 + MM_C3;
        if (more) w <= w + 2'd1;
      end
      H_FIN1: begin
        h1 <= h1 ^ {58'd0, len};
        h2 <= h2 ^ {58'd0, len};
      end
      H_FIN2: h1 <= h1 + h2;
      H_FIN3: h2 <= h2 + h1;
      H_FM2:  if (mdone) begin
        if (sel) h2 <= mixed;
        else h1 <= mixed;
        sel <= 1'b1;
      end
      H_SUM:  hash <= h1 + h2;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/kbms_front.sv
// ----------------------------------------------------------------------------
// kbms_front: request intake, symbol window and command classification
// Keeps the last symbols of the sequence, decides whether a push completes
// a k-mer and builds the key string for the back end, canonical in DNA mode.
// ----------------------------------------------------------------------------
`default_nettype none

module kbms_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kbms_pkg::IN_W-1:0]         s_tdata,
  input  logic [kbms_pkg::KLEN_W-1:0]       klen,
  input  logic                              protein,
  output logic                              q_push,
  output kbms_pkg::cmd_t                    q_entry,
  input  logic                              q_full
);
  import kbms_pkg::*;

  logic [7:0]        window [KMAX];
  logic [KLEN_W-1:0] seen, seen_next, eff_k;
  logic              accept;
  opcode_t           op;
  cmd_kind_t         kind;

  logic              stg_valid;
  cmd_kind_t         stg_kind;
  logic [IDX_W-1:0]  stg_index;
  logic [KLEN_W-1:0] stg_k;
  logic              stg_mode;

  logic [8*KMAX-1:0] wvec, fwd_vec, fwd_str, rev_str;
  logic [2*KMAX-1:0] fwd_codes, rev_codes;
  logic [8:0]        sh_amt;
  logic              use_rev;

  assign op       = opcode_t'(s_tdata[1:0]);
  assign s_tready = !stg_valid || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = stg_valid && !q_full;

  always_comb begin
    if (klen == '0) eff_k = KLEN_W'(1);
    else if (klen > KLEN_W'(KMAX)) eff_k = KLEN_W'(KMAX);
    else eff_k = klen;
    seen_next = (seen < KLEN_W'(KMAX)) ? seen + 1'b1 : seen;
    case (op)
      OP_PUSH:  kind = (seen_next >= eff_k) ? CMD_HASH : CMD_SKIP;
      OP_START: kind = CMD_CLEAR;
      OP_READ:  kind = CMD_READ;
      default:  kind = CMD_SKIP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      stg_valid <= 1'b0;
    end else begin
      if (accept && op == OP_PUSH) seen <= seen_next;
      else if (accept && op == OP_START) seen <= '0;
      if (accept) stg_valid <= 1'b1;
      else if (q_push) stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind  <= kind;
      stg_index <= s_tdata[19:10];
      stg_k     <= eff_k;
      stg_mode  <= protein;
    end
    if (accept && op == OP_PUSH) begin
      for (int i = 0; i < KMAX - 1; i++) window[i] <= window[i+1];
      window[KMAX-1] <= s_tdata[9:2];
    end
  end

  // The forward k-mer is the newest k symbols; the reverse complement reads
  // the window backwards from the newest symbol and so needs no shift.
  always_comb begin
    for (int i = 0; i < KMAX; i++) wvec[8*i +: 8] = window[i];
    sh_amt  = {KLEN_W'(KMAX) - stg_k, 3'b000};
    fwd_vec = wvec >> sh_amt;
    for (int j = 0; j < KMAX; j++) begin
      fwd_codes[2*KMAX-1-2*j -: 2] = (KLEN_W'(j) < stg_k) ? fwd_vec[8*j +: 2] : 2'b00;
      rev_codes[2*KMAX-1-2*j -: 2] = (KLEN_W'(j) < stg_k) ? ~window[KMAX-1-j][1:0] : 2'b00;
      fwd_str[8*j +: 8] = stg_mode ? protein_letter(fwd_vec[8*j +: 8])
                                   : dna_letter(fwd_vec[8*j +: 2]);
      rev_str[8*j +: 8] = dna_letter(~window[KMAX-1-j][1:0]);
    end
    use_rev = !stg_mode && (fwd_codes > rev_codes);
    q_entry.kind  = stg_kind;
    q_entry.index = stg_index;
    q_entry.len   = stg_k;
    q_entry.str   = use_rev ? rev_str : fwd_str;
  end

endmodule

`default_nettype wire

FILE: src/kbms_queue.sv
// ----------------------------------------------------------------------------
// kbms_queue: two-entry command queue between the front and back ends
// Lets the front take the next request while the back end is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module kbms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kbms_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output kbms_pkg::cmd_t dout,
  output logic           empty
);
  import kbms_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   fill;
  logic              do_push, do_pop;

  assign full    = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= din;
  end

endmodule

`default_nettype wire

FILE: src/kbms_back.sv
// ----------------------------------------------------------------------------
// kbms_back: command execution, sorted sketch store and result register
// Hashes completed k-mers, inserts them into the ascending store by moving
// larger entries up one place, and serves indexed reads.
// ----------------------------------------------------------------------------
`default_nettype none

module kbms_back #(
  parameter int SKETCH_SIZE = kbms_pkg::SKETCH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  kbms_pkg::cmd_t             q_entry,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [kbms_pkg::OUT_W-1:0] m_tdata
);
  import kbms_pkg::*;

  localparam int AW = (SKETCH_SIZE > 1) ? $clog2(SKETCH_SIZE) : 1;
  localparam int CW = $clog2(SKETCH_SIZE + 1);
  localparam int WW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [AW-1:0] LAST = AW'(SKETCH_SIZE - 1);

  // Only the first count entries are meaningful; the rest read as all ones.
  logic [63:0]   mem [SKETCH_SIZE];
  logic [63:0]   rd_data, wd;
  logic [AW-1:0] rd_addr, wa, slot;
  logic          we;
  logic [CW-1:0] count;

  back_state_t state, state_next;
  logic        hstart, hdone, out_free, in_range, not_full, fits;
  logic [63:0] hash;
  logic [WW-1:0] idx_w;

  logic        res_hv, res_kept;
  logic [63:0] res_hash, res_entry;

  kbms_murmur u_murmur (
    .clk     (clk),
    .rst     (rst),
    .start   (hstart),
    .key     (q_entry.str),
    .key_len (q_entry.len),
    .done    (hdone),
    .hash    (hash)
  );

  assign out_free = !m_tvalid || m_tready;
  assign idx_w    = WW'(q_entry.index);
  assign in_range = idx_w < WW'(count);
  assign not_full = count < CW'(SKETCH_SIZE);
  // An all-ones hash never beats an empty slot, so it is not stored.
  assign fits     = not_full && (hash != ALL_ONES);

  always_comb begin
    state_next = state;
    q_pop   = 1'b0;
    hstart  = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = slot;
    wd      = res_hash;
    case (state)
      B_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        case (q_entry.kind)
          CMD_HASH: begin
            hstart = 1'b1;
            state_next = B_HASH;
          end
          CMD_READ: begin
            rd_addr = idx_w[AW-1:0];
            state_next = in_range ? B_RDWAIT : B_DONE;
          end
          default: state_next = B_DONE;
        endcase
      end
      B_HASH: if (hdone) begin
        if (fits) begin
          state_next = (count == '0) ? B_PLACE : B_SHRD;
        end else if (not_full) begin
          state_next = B_DONE;
        end else begin
          rd_addr = LAST;
          state_next = B_TOPCMP;
        end
      end
      B_TOPCMP: begin
        if (res_hash < rd_data) state_next = (SKETCH_SIZE == 1) ? B_PLACE : B_SHRD;
        else state_next = B_DONE;
      end
      B_SHRD: begin
        rd_addr = slot - 1'b1;
        state_next = B_SHCMP;
      end
      B_SHCMP: begin
        if (rd_data > res_hash) begin
          we = 1'b1;
          wd = rd_data;
          state_next = (slot == AW'(1)) ? B_PLACE : B_SHRD;
        end else begin
          state_next = B_PLACE;
        end
      end
      B_PLACE: begin
        we = 1'b1;
        state_next = B_DONE;
      end
      B_RDWAIT: state_next = B_DONE;
      B_DONE:   if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE && !q_empty && q_entry.kind == CMD_CLEAR) count <= '0;
      else if (state == B_HASH && hdone && fits) count <= count + 1'b1;
      if (state == B_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: if (!q_empty) begin
        res_hv    <= 1'b0;
        res_hash  <= '0;
        res_kept  <= 1'b0;
        res_entry <= (q_entry.kind == CMD_READ && !in_range) ? ALL_ONES : 64'd0;
      end
      B_HASH: if (hdone) begin
        res_hv   <= 1'b1;
        res_hash <= hash;
        if (fits) begin
          res_kept <= 1'b1;
          slot     <= count[AW-1:0];
        end
      end
      B_TOPCMP: if (res_hash < rd_data) begin
        res_kept <= 1'b1;
        slot     <= LAST;
      end
      B_SHCMP:  if (rd_data > res_hash) slot <= slot - 1'b1;
      B_RDWAIT: res_entry <= rd_data;
      B_DONE:   if (out_free) m_tdata <= {6'd0, res_entry, res_kept, res_hash, res_hv};
      default: ;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SKETCH_SIZE))
    else $error("sketch fill count beyond store size");

  a_write_filled: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(wa) < count))
    else $error("sketch write outside the filled region");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE && !q_empty && q_entry.kind == CMD_CLEAR) |=> (count == '0))
    else $error("start of sequence did not empty the sketch");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && out_free) |=> (m_tvalid && state == B_IDLE))
    else $error("finished command not presented on the output");

endmodule

`default_nettype wire
